>>> sv/iirl_pkg.sv
// ----------------------------------------------------------------------------
// iirl_pkg
// Shared codes, defaults and types for the indexed insert/remove list unit.
// ----------------------------------------------------------------------------
package iirl_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 6;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

>>> sv/indexed_insert_remove_list_unit.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_unit
// Fixed-capacity ordered word list with indexed insert, remove and read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   append, prepend, insert at position, remove at position or read.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result per
//   command: the word read or removed, a status, the count and an empty flag.
//   The result is registered in the output register at the edge the command
//   is taken. One command per cycle is sustained while the receiver takes
//   results; every entry lives in its own cell and all cells shift together
//   in that same cycle, so the rate is set by the output register alone.
//   When the receiver stalls, the result holds and o_in_stall rises until
//   it is taken. Reset empties the list at once (count to zero, no result
//   pending); entry contents need no clearing as only entries below the
//   count are ever read.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_unit #(
    parameter int CAPACITY   = iirl_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = iirl_pkg::WORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [iirl_pkg::CMD_W-1:0]  i_command,
    input  logic [iirl_pkg::POS_W-1:0]  i_position,
    input  logic [iirl_pkg::VAL_W-1:0]  i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [iirl_pkg::VAL_W-1:0]  o_word_out,
    output logic [iirl_pkg::STAT_W-1:0] o_status,
    output logic [iirl_pkg::CNT_W-1:0]  o_count,
    output logic                        o_is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > iirl_pkg::POS_W) ? CW : iirl_pkg::POS_W;
    localparam int WX = (WORD_WIDTH > iirl_pkg::VAL_W) ? WORD_WIDTH : iirl_pkg::VAL_W;

    logic [CW-1:0]               r_fill;
    logic [CW-1:0]               n_fill;
    logic                        r_out_valid;
    logic [iirl_pkg::VAL_W-1:0]  r_word;
    logic [iirl_pkg::STAT_W-1:0] r_status;
    logic [iirl_pkg::CNT_W-1:0]  r_count;
    logic                        r_empty;

    logic                        w_accept;
    logic [XW-1:0]               w_pos;
    logic [XW-1:0]               w_fill;
    logic [XW-1:0]               w_eff_pos;
    logic [XW-1:0]               w_new_fill;
    logic                        w_full;
    logic                        w_take;
    logic [iirl_pkg::STAT_W-1:0] w_status;
    iirl_pkg::t_cell_cmd         w_cmd;
    logic [WORD_WIDTH-1:0]       w_new;
    logic [WORD_WIDTH-1:0]       w_sel;
    logic [WX-1:0]               w_sel_x;

    logic [WORD_WIDTH-1:0]       w_data [CAPACITY];
    logic [WORD_WIDTH-1:0]       w_hit  [CAPACITY];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_pos      = XW'(i_position);
    assign w_fill     = XW'(r_fill);
    assign w_full     = (w_fill == XW'(CAPACITY));
    assign w_new      = WORD_WIDTH'(i_value);

    always_comb begin
        w_status  = iirl_pkg::ST_OK;
        w_eff_pos = w_pos;
        w_cmd     = '0;
        w_take    = 1'b0;
        case (i_command)
            iirl_pkg::CMD_APPEND: begin
                w_eff_pos = w_fill;
                if (w_full) begin
                    w_status = iirl_pkg::ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                end
            end
            iirl_pkg::CMD_PREPEND: begin
                w_eff_pos = '0;
                if (w_full) begin
                    w_status = iirl_pkg::ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                end
            end
            iirl_pkg::CMD_INSERT: begin
                if (w_pos > w_fill) begin
                    w_status = iirl_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = iirl_pkg::ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                end
            end
            iirl_pkg::CMD_REMOVE: begin
                if (w_pos >= w_fill) begin
                    w_status = iirl_pkg::ST_RANGE;
                end else begin
                    w_cmd.rem = 1'b1;
                    w_take    = 1'b1;
                end
            end
            iirl_pkg::CMD_READ: begin
                if (w_pos >= w_fill) begin
                    w_status = iirl_pkg::ST_RANGE;
                end else begin
                    w_take = 1'b1;
                end
            end
            default: begin
                w_status = iirl_pkg::ST_RANGE;
            end
        endcase
        if (!w_accept) begin
            w_cmd = '0;
        end
    end

    always_comb begin
        if (w_cmd.ins) begin
            w_new_fill = w_fill + XW'(1);
        end else if (w_cmd.rem) begin
            w_new_fill = w_fill - XW'(1);
        end else begin
            w_new_fill = w_fill;
        end
        n_fill = CW'(w_new_fill);
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [WORD_WIDTH-1:0] w_prev;
            logic [WORD_WIDTH-1:0] w_next;
            if (g == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid
                assign w_prev = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_next = w_data[g];
            end else begin : g_body
                assign w_next = w_data[g+1];
            end
            iirl_cell #(
                .IDX   (g),
                .XW    (XW),
                .WIDTH (WORD_WIDTH)
            ) u_cell (
                .i_clk  (i_clk),
                .i_cmd  (w_cmd),
                .i_pos  (w_eff_pos),
                .i_new  (w_new),
                .i_prev (w_prev),
                .i_next (w_next),
                .o_data (w_data[g]),
                .o_hit  (w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        w_sel = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            w_sel = w_sel | w_hit[j];
        end
        w_sel_x = WX'(w_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word   <= w_take ? w_sel_x[iirl_pkg::VAL_W-1:0] : '0;
            r_status <= w_status;
            r_count  <= w_new_fill[iirl_pkg::CNT_W-1:0];
            r_empty  <= (w_new_fill == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word_out  = r_word;
    assign o_status    = r_status;
    assign o_count     = r_count;
    assign o_is_empty  = r_empty;

endmodule

>>> sv/iirl_cell.sv
// ----------------------------------------------------------------------------
// iirl_cell
// One list entry: holds, loads, or takes a word from either neighbour.
// ----------------------------------------------------------------------------
module iirl_cell #(
    parameter int IDX   = 0,
    parameter int XW    = 6,
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  iirl_pkg::t_cell_cmd  i_cmd,
    input  logic [XW-1:0]        i_pos,
    input  logic [WIDTH-1:0]     i_new,
    input  logic [WIDTH-1:0]     i_prev,
    input  logic [WIDTH-1:0]     i_next,
    output logic [WIDTH-1:0]     o_data,
    output logic [WIDTH-1:0]     o_hit
);

    localparam logic [XW-1:0] Idx = XW'(IDX);

    logic [WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (Idx > i_pos) begin
                r_data <= i_prev;
            end else if (Idx == i_pos) begin
                r_data <= i_new;
            end
        end else if (i_cmd.rem) begin
            if (Idx >= i_pos) begin
                r_data <= i_next;
            end
        end
    end

    assign o_data = r_data;
    assign o_hit  = (Idx == i_pos) ? r_data : '0;

endmodule

>>> sv/iirl_checker.sv
// ----------------------------------------------------------------------------
// iirl_checker
// Port-level checks for the indexed insert/remove list unit.
// ----------------------------------------------------------------------------
module iirl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [iirl_pkg::CMD_W-1:0]  i_command,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [iirl_pkg::VAL_W-1:0]  o_word_out,
    input logic [iirl_pkg::STAT_W-1:0] o_status,
    input logic [iirl_pkg::CNT_W-1:0]  o_count,
    input logic                        o_is_empty
);

    // a taken command always yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("no result after command transfer");

    // failed commands return no word
    a_error_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != iirl_pkg::ST_OK) |-> (o_word_out == '0))
        else $error("word returned on error");

    // an empty list reports a zero count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> (o_count == '0))
        else $error("empty flag with nonzero count");

    // a full list is only reported for storing commands
    a_full_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command != iirl_pkg::CMD_APPEND)
        && (i_command != iirl_pkg::CMD_PREPEND) && (i_command != iirl_pkg::CMD_INSERT)
        |=> (o_status != iirl_pkg::ST_FULL))
        else $error("full status on non-storing command");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_word_out)
        && $stable(o_status) && $stable(o_count))
        else $error("stalled result changed");

endmodule

bind indexed_insert_remove_list_unit iirl_checker u_iirl_checker (.*);
